// ===== hw/rtl/qet_pkg.sv =====
package qet_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int ITER_BITS = 10;
    localparam int ADDR_BITS = 5;
    localparam int DIV_STEPS = 64 + FRAC_BITS - 1;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [63:0] ESC_LIMIT = 64'd1000 << (2 * FRAC_BITS);

    localparam logic [2:0] REG_LAMBDA_RE = 3'd0;
    localparam logic [2:0] REG_LAMBDA_IM = 3'd1;
    localparam logic [2:0] REG_CUBIC_RE  = 3'd2;
    localparam logic [2:0] REG_CUBIC_IM  = 3'd3;
    localparam logic [2:0] REG_MAX_ITER  = 3'd4;

    localparam logic [31:0] RST_LAMBDA_RE = 32'd16777216;
    localparam logic [31:0] RST_CUBIC_RE  = 32'd16777216;
    localparam logic [ITER_BITS-1:0] RST_MAX_ITER = 10'd50;

    typedef enum logic [4:0] {
        S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_CM, S_ADDL, S_RAW,
        S_DIVR, S_DIVI, S_INIT, S_CHK, S_SUB, S_ADDQ, S_ADDM, S_UPD
    } t_state;

    typedef struct packed {
        logic                        ov;
        logic signed [WORD_BITS-1:0] v;
    } t_sat;

    typedef struct packed {
        logic                        done;
        logic                        ov;
        logic signed [WORD_BITS-1:0] quo;
    } t_div_res;

    function automatic t_sat sat_add(logic signed [WORD_BITS-1:0] a,
                                     logic signed [WORD_BITS-1:0] b);
        logic signed [WORD_BITS:0] s;
        t_sat r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        r.ov = s[WORD_BITS] != s[WORD_BITS-1];
        r.v = r.ov ? (s[WORD_BITS] ? WMIN : WMAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    function automatic t_sat sat_sub(logic signed [WORD_BITS-1:0] a,
                                     logic signed [WORD_BITS-1:0] b);
        logic signed [WORD_BITS:0] s;
        t_sat r;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        r.ov = s[WORD_BITS] != s[WORD_BITS-1];
        r.v = r.ov ? (s[WORD_BITS] ? WMIN : WMAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    // Floors the exact product to the fraction width, then saturates.
    function automatic t_sat fx_scale(logic signed [2*WORD_BITS-1:0] p);
        t_sat r;
        r.ov = !((&p[2*WORD_BITS-1:FRAC_BITS+WORD_BITS-1]) ||
                 !(|p[2*WORD_BITS-1:FRAC_BITS+WORD_BITS-1]));
        r.v = r.ov ? (p[2*WORD_BITS-1] ? WMIN : WMAX)
                   : p[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
        return r;
    endfunction

endpackage

// ===== hw/rtl/qet_mul.sv =====
module qet_mul
    import qet_pkg::*;
(
    input  logic                          i_clk,
    input  logic signed [WORD_BITS-1:0]   i_a,
    input  logic signed [WORD_BITS-1:0]   i_b,
    output logic signed [2*WORD_BITS-1:0] o_p
);

    logic signed [2*WORD_BITS-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/qet_div.sv =====
module qet_div
    import qet_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [64:0]  i_num,
    input  logic [63:0]         i_den,
    output t_div_res            o_res
);

    logic                      r_busy;
    logic                      r_done;
    logic [DIV_CNT_BITS-1:0]   r_cnt;
    logic [63:0]               r_dv;
    logic [63:0]               r_rem;
    logic [63:0]               r_den;
    logic [WORD_BITS:0]        r_q;
    logic                      r_big;
    logic                      r_pos;
    logic [64:0]               num_mag;
    logic [64:0]               sh;
    logic                      ge;
    logic [64:0]               diff;
    logic                      ov;

    assign num_mag = i_num[64] ? 65'(-i_num) : 65'(i_num);
    assign sh = {r_rem, r_dv[63]};
    assign ge = sh >= {1'b0, r_den};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_BITS'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dv  <= num_mag[63:0];
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= '0;
            r_big <= 1'b0;
            r_pos <= !i_num[64];
        end else if (r_busy) begin
            r_dv  <= {r_dv[62:0], 1'b0};
            r_rem <= ge ? diff[63:0] : sh[63:0];
            r_q   <= {r_q[WORD_BITS-1:0], ge};
            r_big <= r_big | r_q[WORD_BITS];
        end
    end

    // A nonnegative numerator gives a negative quotient.
    always_comb begin
        if (r_pos) begin
            ov = r_big || (r_q > {2'b01, {(WORD_BITS-1){1'b0}}});
            o_res.quo = ov ? WMIN : -$signed(r_q[WORD_BITS-1:0]);
        end else begin
            ov = r_big || r_q[WORD_BITS] || r_q[WORD_BITS-1];
            o_res.quo = ov ? WMAX : $signed(r_q[WORD_BITS-1:0]);
        end
        o_res.ov = ov;
        o_res.done = r_done;
    end

endmodule

// ===== hw/rtl/quartic_escape_time.sv =====
// Escape-time iteration of a quartic map for one plane point per request.
// A request is accepted at a rising edge with start high and busy low; the
// point is taken from i_point_re and i_point_im (signed Q8.24). Coefficients
// and the iteration limit are to be written over the APB port only while busy
// is low; the block does not enforce this. pready is always high and reads
// return the stored values. Setup forms the quadratic coefficient with one
// shared multiplier, a shared saturating complex adder and a bit-serial
// divider (two quotients, unless the denominator is zero). Each orbit step
// then runs an escape check, three complex products on the shared multiplier
// and then the add and update steps; busy stays high throughout a request.
// The result appears on o_stayed_bounded and o_iterations, marked by o_valid
// high for exactly one cycle, as busy falls. The receiver cannot stall.
// Reset restores the register defaults and returns the block to idle.
module quartic_escape_time
    import qet_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_BITS-1:0]        paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [WORD_BITS-1:0] i_point_re,
    input  logic signed [WORD_BITS-1:0] i_point_im,
    output logic                        o_valid,
    output logic                        o_stayed_bounded,
    output logic [ITER_BITS-1:0]        o_iterations
);

    logic signed [31:0]          r_lam_re, r_lam_im, r_cub_re, r_cub_im;
    logic [ITER_BITS-1:0]        r_max_iter;

    t_state r_state, n_state, r_ret, n_ret;
    logic [2:0]                  r_ph, n_ph;

    logic signed [WORD_BITS-1:0] r_pt_re, r_pt_im, r_t_re, r_t_im;
    logic signed [WORD_BITS-1:0] r_z_re, r_z_im, r_q_re, r_q_im;
    logic signed [WORD_BITS-1:0] r_acc, r_nre;
    logic [63:0]                 r_den;
    logic signed [64:0]          r_nr, r_ni;
    logic                        r_ova, r_sov, r_esc;
    logic [ITER_BITS-1:0]        r_n;
    logic                        r_valid, r_res_b;
    logic [ITER_BITS-1:0]        r_res_n;

    logic signed [WORD_BITS-1:0]   m_a, m_b, y_re, y_im;
    logic signed [2*WORD_BITS-1:0] m_p;
    t_sat                          fp, cm_re, cm_im;
    logic signed [WORD_BITS-1:0]   x_re, x_im, a_re, a_im;
    logic                          add_sub;
    t_sat                          add_re, add_im;
    logic                          div_start;
    logic signed [64:0]            div_num;
    t_div_res                      dres;
    logic [64:0]                   norm;
    logic                          chk_fin, ysel;
    logic                          cfg_wr;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam_re   <= RST_LAMBDA_RE;
            r_lam_im   <= '0;
            r_cub_re   <= RST_CUBIC_RE;
            r_cub_im   <= '0;
            r_max_iter <= RST_MAX_ITER;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_LAMBDA_RE: r_lam_re   <= pwdata;
                REG_LAMBDA_IM: r_lam_im   <= pwdata;
                REG_CUBIC_RE:  r_cub_re   <= pwdata;
                REG_CUBIC_IM:  r_cub_im   <= pwdata;
                REG_MAX_ITER:  r_max_iter <= pwdata[ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LAMBDA_RE: prdata = r_lam_re;
            REG_LAMBDA_IM: prdata = r_lam_im;
            REG_CUBIC_RE:  prdata = r_cub_re;
            REG_CUBIC_IM:  prdata = r_cub_im;
            REG_MAX_ITER:  prdata = {{(32-ITER_BITS){1'b0}}, r_max_iter};
            default:       prdata = '0;
        endcase
    end

    // Shared multiplier.
    assign ysel = (r_ret == S_ADDQ) || (r_ret == S_ADDM) || (r_ret == S_UPD);
    assign y_re = ysel ? r_z_re : r_pt_re;
    assign y_im = ysel ? r_z_im : r_pt_im;

    always_comb begin
        m_a = r_t_re;
        m_b = y_re;
        case (r_state)
            S_CM: begin
                case (r_ph)
                    3'd1: begin m_a = r_t_im; m_b = y_im; end
                    3'd2: begin m_a = r_t_re; m_b = y_im; end
                    3'd3: begin m_a = r_t_im; m_b = y_re; end
                    default: ;
                endcase
            end
            S_RAW: begin
                case (r_ph)
                    3'd0: begin m_a = r_pt_re; m_b = r_pt_re; end
                    3'd1: begin m_a = r_pt_im; m_b = r_pt_im; end
                    3'd2: begin m_a = r_t_re;  m_b = r_pt_re; end
                    3'd3: begin m_a = r_t_im;  m_b = r_pt_im; end
                    3'd4: begin m_a = r_t_im;  m_b = r_pt_re; end
                    default: begin m_a = r_t_re; m_b = r_pt_im; end
                endcase
            end
            S_CHK: begin
                if (r_ph == 3'd0) begin
                    m_a = r_z_re;
                    m_b = r_z_re;
                end else begin
                    m_a = r_z_im;
                    m_b = r_z_im;
                end
            end
            default: ;
        endcase
    end

    qet_mul u_mul (
        .i_clk (i_clk),
        .i_a   (m_a),
        .i_b   (m_b),
        .o_p   (m_p)
    );

    assign fp    = fx_scale(m_p);
    assign cm_re = sat_sub(r_acc, fp.v);
    assign cm_im = sat_add(r_acc, fp.v);

    // Shared saturating complex adder.
    always_comb begin
        x_re = r_t_re;
        x_im = r_t_im;
        a_re = r_lam_re;
        a_im = r_lam_im;
        add_sub = 1'b0;
        case (r_state)
            S_P0: begin
                x_re = r_cub_re; x_im = r_cub_im;
                a_re = r_cub_re; a_im = r_cub_im;
            end
            S_P1: begin a_re = r_cub_re; a_im = r_cub_im; end
            S_P2: begin
                x_re = r_pt_re; x_im = r_pt_im;
                a_re = r_pt_re; a_im = r_pt_im;
            end
            S_P3: begin
                x_re = r_z_re; x_im = r_z_im;
                a_re = r_z_re; a_im = r_z_im;
            end
            S_P4: begin a_re = r_z_re; a_im = r_z_im; add_sub = 1'b1; end
            S_SUB: begin
                x_re = r_cub_re; x_im = r_cub_im;
                a_re = r_z_re;   a_im = r_z_im;
                add_sub = 1'b1;
            end
            S_ADDQ: begin a_re = r_q_re; a_im = r_q_im; end
            default: ;
        endcase
        add_re = add_sub ? sat_sub(x_re, a_re) : sat_add(x_re, a_re);
        add_im = add_sub ? sat_sub(x_im, a_im) : sat_add(x_im, a_im);
    end

    // Divider.
    assign div_start = ((r_state == S_RAW) && (r_ph == 3'd6) && (r_den != '0)) ||
                       ((r_state == S_DIVR) && dres.done);
    assign div_num = (r_state == S_RAW) ? r_nr : r_ni;

    qet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_res   (dres)
    );

    assign norm = {1'b0, r_den} + {1'b0, m_p};
    assign chk_fin = (r_state == S_CHK) &&
                     (((r_ph == 3'd0) && ((r_n == r_max_iter) || r_esc)) ||
                      ((r_ph == 3'd2) && (norm >= {1'b0, ESC_LIMIT})));

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_ph    <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ph    <= n_ph;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        case (r_state)
            S_IDLE: if (start) n_state = S_P0;
            S_P0:   n_state = S_P1;
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_P3;
            S_P3:   n_state = S_P4;
            S_P4: begin n_state = S_CM; n_ret = S_P5; end
            S_P5: begin n_state = S_CM; n_ret = S_ADDL; end
            S_CM:   if (r_ph == 3'd4) n_state = r_ret;
            S_ADDL: n_state = S_RAW;
            S_RAW: begin
                if (r_ph == 3'd6) n_state = (r_den == '0) ? S_INIT : S_DIVR;
            end
            S_DIVR: if (dres.done) n_state = S_DIVI;
            S_DIVI: if (dres.done) n_state = S_INIT;
            S_INIT: n_state = S_CHK;
            S_CHK: begin
                if (chk_fin) n_state = S_IDLE;
                else if (r_ph == 3'd2) n_state = S_SUB;
            end
            S_SUB:  begin n_state = S_CM; n_ret = S_ADDQ; end
            S_ADDQ: begin n_state = S_CM; n_ret = S_ADDM; end
            S_ADDM: begin n_state = S_CM; n_ret = S_UPD; end
            S_UPD:  n_state = S_CHK;
            default: n_state = S_IDLE;
        endcase
        n_ph = (n_state == r_state) ? r_ph + 3'd1 : 3'd0;
    end

    assign busy = r_state != S_IDLE;

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chk_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chk_fin) begin
            r_res_b <= r_n == r_max_iter;
            r_res_n <= r_n;
        end
        case (r_state)
            S_IDLE: begin
                r_pt_re <= i_point_re;
                r_pt_im <= i_point_im;
                r_ova   <= 1'b0;
            end
            S_P0, S_P1, S_P4, S_ADDL, S_ADDQ, S_ADDM: begin
                r_t_re <= add_re.v;
                r_t_im <= add_im.v;
                r_ova  <= r_ova | add_re.ov | add_im.ov;
            end
            S_P2, S_P3: begin
                r_z_re <= add_re.v;
                r_z_im <= add_im.v;
                r_ova  <= r_ova | add_re.ov | add_im.ov;
            end
            S_SUB: begin
                r_t_re <= add_re.v;
                r_t_im <= add_im.v;
                r_ova  <= r_sov | add_re.ov | add_im.ov;
            end
            S_CM: begin
                case (r_ph)
                    3'd1, 3'd3: begin
                        r_acc <= fp.v;
                        r_ova <= r_ova | fp.ov;
                    end
                    3'd2: begin
                        r_nre <= cm_re.v;
                        r_ova <= r_ova | fp.ov | cm_re.ov;
                    end
                    3'd4: begin
                        r_t_re <= r_nre;
                        r_t_im <= cm_im.v;
                        r_ova  <= r_ova | fp.ov | cm_im.ov;
                    end
                    default: ;
                endcase
            end
            S_RAW: begin
                case (r_ph)
                    3'd1: r_den <= m_p;
                    3'd2: r_den <= r_den + m_p;
                    3'd3: r_nr  <= {m_p[63], m_p};
                    3'd4: r_nr  <= r_nr + {m_p[63], m_p};
                    3'd5: r_ni  <= {m_p[63], m_p};
                    3'd6: begin
                        r_ni <= r_ni - {m_p[63], m_p};
                        if (r_den == '0) begin
                            r_ova  <= 1'b1;
                            r_q_re <= '0;
                            r_q_im <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            S_DIVR: begin
                if (dres.done) begin
                    r_q_re <= dres.quo;
                    r_ova  <= r_ova | dres.ov;
                end
            end
            S_DIVI: begin
                if (dres.done) begin
                    r_q_im <= dres.quo;
                    r_ova  <= r_ova | dres.ov;
                end
            end
            S_INIT: begin
                r_z_re <= r_pt_re;
                r_z_im <= r_pt_im;
                r_n    <= '0;
                r_esc  <= 1'b0;
                r_sov  <= r_ova;
            end
            S_CHK: begin
                if (r_ph == 3'd1) r_den <= m_p;
            end
            S_UPD: begin
                r_z_re <= r_t_re;
                r_z_im <= r_t_im;
                r_esc  <= r_ova;
                r_n    <= r_n + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid          = r_valid;
    assign o_stayed_bounded = r_res_b;
    assign o_iterations     = r_res_n;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while a request is still in progress");

    a_iter_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_iterations <= r_max_iter))
        else $error("iteration count beyond the limit");

    a_bounded_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stayed_bounded) |-> (o_iterations == r_max_iter))
        else $error("bounded result with a count other than the limit");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dres.done |-> ((r_state == S_DIVR) || (r_state == S_DIVI)))
        else $error("divider finished outside a division wait");

endmodule
